>>> hw/rtl/est_pkg.sv
// est_pkg: shared widths, status codes and result type for the elevation sequence tracker
// no dependencies; used by the channel interfaces, the top level and the checker

package est_pkg;

  localparam int unsigned ELEV_W   = 15;
  localparam int unsigned TOL_W    = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SIDX_W   = 8;

  localparam logic [TOL_W-1:0] TOL_RESET = 10'd20;  // 0.20 degree

  // result status codes
  localparam logic [STATUS_W-1:0] ST_IN_SEQUENCE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESYNCED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOST        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STORED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

  // input item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_SWEEP = 1'b1;

  typedef struct packed {
    logic                       keep;
    logic [STATUS_W-1:0]        status;
    logic signed [SIDX_W-1:0]   state_index;
  } est_result_t;

endpackage

>>> hw/rtl/est_in_if.sv
// est_in_if: valid/ready channel carrying one input item (store or sweep)
// depends on est_pkg for field widths

interface est_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [est_pkg::ELEV_W-1:0]   elevation;
  logic                                keep_flag;

  modport source (output valid, output kind, output elevation, output keep_flag,
                  input ready);
  modport sink   (input valid, input kind, input elevation, input keep_flag,
                  output ready);
endinterface

>>> hw/rtl/est_out_if.sv
// est_out_if: valid/ready channel carrying one result item
// depends on est_pkg for field widths

interface est_out_if;
  logic                                valid;
  logic                                ready;
  logic                                keep;
  logic [est_pkg::STATUS_W-1:0]        status;
  logic signed [est_pkg::SIDX_W-1:0]   state_index;

  modport source (output valid, output keep, output status, output state_index,
                  input ready);
  modport sink   (input valid, input keep, input status, input state_index,
                  output ready);
endinterface

>>> hw/rtl/elevation_sequence_tracker.sv
// elevation_sequence_tracker: follows a cyclic radar scan schedule and classifies sweeps
// depends on est_pkg, est_in_if and est_out_if

// A store item appends one schedule entry (expected elevation and keep flag) to an
// on-chip table of MAX_ENTRIES entries; a store into a full table is dropped and
// answered with status "table full". A sweep item is first compared with the entry
// after the current position (wrapping to entry 0); on a mismatch the table is scanned
// from entry 0 for the first entry within tolerance (|measured - expected| strictly
// below match_tolerance). Every input item yields exactly one result. A store item, and
// a sweep into an empty table, go from idle straight to the done state; a sweep first
// compares the expected entry and, on a mismatch, scans at most the number of stored
// entries. The single table read port and the single shared compare unit together
// check one entry per cycle. Input ready is high only while the sequencer is idle; a
// finished result sits in the output register while the next item is accepted.
// The user must write match_tolerance through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this.

module elevation_sequence_tracker #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [est_pkg::TOL_W-1:0]    cfg_wdata_i,
  est_in_if.sink                       in_i,
  est_out_if.source                    out_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned POS_W = (IDX_W > est_pkg::SIDX_W) ? IDX_W : est_pkg::SIDX_W;
  localparam int unsigned DIF_W = est_pkg::ELEV_W + 1;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NEXT = 2'd1;  // data of the expected entry is on the read port
  localparam logic [1:0] S_SCAN = 2'd2;  // resync scan, one entry per cycle
  localparam logic [1:0] S_DONE = 2'd3;  // result waits for the output register

  // schedule table
  logic signed [est_pkg::ELEV_W-1:0] mem_elev [MAX_ENTRIES];
  logic                              mem_keep [MAX_ENTRIES];

  logic [1:0]                         state_q, state_d;
  logic [CNT_W-1:0]                   count_q;
  logic [IDX_W-1:0]                   pos_q, pos_d;
  logic                               lost_q, lost_d;
  logic [est_pkg::TOL_W-1:0]          tol_q;
  logic signed [est_pkg::ELEV_W-1:0]  elev_q;
  logic [IDX_W-1:0]                   cmp_idx_q, cmp_idx_d;
  est_pkg::est_result_t               res_q, res_d;
  est_pkg::est_result_t               out_res_q;
  logic                               out_valid_q;

  logic [IDX_W-1:0]                   rd_addr;
  logic signed [est_pkg::ELEV_W-1:0]  rd_elev_q;
  logic                               rd_keep_q;

  logic                               in_xfer;
  logic                               out_load;
  logic                               mem_we;
  logic                               table_full;
  logic [CNT_W:0]                     pos_plus1;
  logic [CNT_W:0]                     cmp_plus1;
  logic [IDX_W-1:0]                   next_idx;

  // shared compare unit
  logic signed [DIF_W-1:0]            diff;
  logic [DIF_W-1:0]                   abs_diff;
  logic                               match;

  function automatic logic [est_pkg::SIDX_W-1:0] state_index_of(
    input logic             lost,
    input logic [IDX_W-1:0] pos
  );
    logic [POS_W-1:0] wide;
    wide = POS_W'(pos);
    return lost ? '1 : wide[est_pkg::SIDX_W-1:0];
  endfunction

  assign in_i.ready       = (state_q == S_IDLE);
  assign in_xfer          = in_i.valid && in_i.ready;
  assign table_full       = (count_q == CNT_W'(MAX_ENTRIES));
  assign mem_we           = in_xfer && (in_i.kind == est_pkg::KIND_STORE) && !table_full;
  assign out_load         = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign diff     = DIF_W'(elev_q) - DIF_W'(rd_elev_q);
  assign abs_diff = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
  assign match    = abs_diff < DIF_W'(tol_q);

  // position after the current one, wrapping past the last stored entry
  assign pos_plus1 = (CNT_W+1)'(pos_q) + 1'b1;
  assign next_idx  = (lost_q || (pos_plus1 >= {1'b0, count_q})) ? '0 : IDX_W'(pos_plus1);
  assign cmp_plus1 = (CNT_W+1)'(cmp_idx_q) + 1'b1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    lost_d    = lost_q;
    cmp_idx_d = cmp_idx_q;
    res_d     = res_q;
    rd_addr   = next_idx;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.kind == est_pkg::KIND_STORE) begin
            res_d.keep        = 1'b0;
            res_d.status      = table_full ? est_pkg::ST_FULL : est_pkg::ST_STORED;
            res_d.state_index = state_index_of(lost_q, pos_q);
            state_d           = S_DONE;
          end else if (count_q == '0) begin
            // empty table: nothing can match
            lost_d            = 1'b1;
            res_d.keep        = 1'b1;
            res_d.status      = est_pkg::ST_LOST;
            res_d.state_index = '1;
            state_d           = S_DONE;
          end else begin
            cmp_idx_d = next_idx;
            state_d   = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (match) begin
          pos_d             = cmp_idx_q;
          lost_d            = 1'b0;
          res_d.keep        = rd_keep_q;
          res_d.status      = est_pkg::ST_IN_SEQUENCE;
          res_d.state_index = state_index_of(1'b0, cmp_idx_q);
          state_d           = S_DONE;
        end else begin
          // mismatch: scan from entry 0
          rd_addr   = '0;
          cmp_idx_d = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = IDX_W'(cmp_plus1);
        if (match) begin
          pos_d             = cmp_idx_q;
          lost_d            = 1'b0;
          res_d.keep        = 1'b1;
          res_d.status      = est_pkg::ST_RESYNCED;
          res_d.state_index = state_index_of(1'b0, cmp_idx_q);
          state_d           = S_DONE;
        end else if (cmp_plus1 == {1'b0, count_q}) begin
          lost_d            = 1'b1;
          res_d.keep        = 1'b1;
          res_d.status      = est_pkg::ST_LOST;
          res_d.state_index = '1;
          state_d           = S_DONE;
        end else begin
          cmp_idx_d = IDX_W'(cmp_plus1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      lost_q      <= 1'b1;
      tol_q       <= est_pkg::TOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      lost_q  <= lost_d;
      if (mem_we) begin
        count_q <= count_q + 1'b1;
      end
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    if (in_xfer) begin
      elev_q <= in_i.elevation;
    end
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  // table write port (append) and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_elev[count_q[IDX_W-1:0]] <= in_i.elevation;
      mem_keep[count_q[IDX_W-1:0]] <= in_i.keep_flag;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_elev_q <= mem_elev[rd_addr];
    rd_keep_q <= mem_keep[rd_addr];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.keep        = out_res_q.keep;
  assign out_o.status      = out_res_q.status;
  assign out_o.state_index = out_res_q.state_index;

endmodule

>>> hw/rtl/est_checker.sv
// est_checker: port-level assertions for the elevation sequence tracker
// depends on est_pkg; bound to elevation_sequence_tracker at the end of this file

module est_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              out_keep_i,
  input logic [est_pkg::STATUS_W-1:0]      out_status_i,
  input logic [est_pkg::SIDX_W-1:0]        out_state_index_i
);

  // a result is held until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("result dropped or changed before transfer");

  // one item at a time: ready drops right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in work");

  // status codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= est_pkg::ST_FULL)
    else $error("status code out of range");

  // a lost result reports position -1 and keeps the sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == est_pkg::ST_LOST |-> out_keep_i && out_state_index_i == '1)
    else $error("lost result with wrong keep or position");

  // store results never keep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == est_pkg::ST_STORED || out_status_i == est_pkg::ST_FULL)
    |-> !out_keep_i)
    else $error("store result with keep set");

endmodule

bind elevation_sequence_tracker est_checker u_est_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_keep_i        (out_o.keep),
  .out_status_i      (out_o.status),
  .out_state_index_i (out_o.state_index)
);

>>> tb/sv/tb_elevation_sequence_tracker.sv
// tb_elevation_sequence_tracker: self-checking bench for the elevation sequence tracker
// depends on est_pkg, est_in_if, est_out_if and elevation_sequence_tracker

module tb_elevation_sequence_tracker;

  localparam int TABLE_DEPTH  = 128;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLDOFF_LEN  = 400;   // long receiver stall, fills the block up
  localparam int TAIL_CYCLES  = 140;   // covers the slowest sweep, a scan of the full table
  localparam int NUM_PHASES   = 6;

  localparam logic signed [est_pkg::ELEV_W-1:0] ELEV_MIN = 15'h4000;
  localparam logic signed [est_pkg::ELEV_W-1:0] ELEV_MAX = 15'h3FFF;
  localparam logic signed [est_pkg::SIDX_W-1:0] IDX_LOST = 8'hFF;
  localparam est_pkg::est_result_t              NO_RESULT = '0;

  // one directed row: the item plus, where obvious, the result typed in
  typedef struct packed {
    logic                                kind;
    logic signed [est_pkg::ELEV_W-1:0]   elev;
    logic                                keep_flag;
    logic                                typed;
    est_pkg::est_result_t                want;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [est_pkg::TOL_W-1:0] cfg_wdata;

  est_in_if  item_ch ();
  est_out_if result_ch ();

  elevation_sequence_tracker #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (item_ch),
    .out_o       (result_ch)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // schedule predictor: own copy of the table, position and tolerance
  // ---------------------------------------------------------------------------
  logic signed [est_pkg::ELEV_W-1:0] sched_elev [TABLE_DEPTH];
  logic                              sched_keep [TABLE_DEPTH];
  int                                entry_cnt;
  int                                cur_pos;
  int                                tol_model;

  est_pkg::est_result_t classified_due [$];   // results owed by the block, oldest first

  function automatic bit within_tol(logic signed [est_pkg::ELEV_W-1:0] a,
                                    logic signed [est_pkg::ELEV_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < tol_model;   // strict, so a zero tolerance never matches
  endfunction

  function automatic est_pkg::est_result_t track_schedule(
    logic kind, logic signed [est_pkg::ELEV_W-1:0] elev, logic kflag);
    est_pkg::est_result_t r;
    int                   nxt;
    int                   hit;
    int                   i;
    r = '0;
    if (kind == est_pkg::KIND_STORE) begin
      // store: append unless full, position untouched
      if (entry_cnt >= TABLE_DEPTH) begin
        r.status = est_pkg::ST_FULL;
      end else begin
        sched_elev[entry_cnt] = elev;
        sched_keep[entry_cnt] = kflag;
        entry_cnt++;
        r.status = est_pkg::ST_STORED;
      end
    end else if (entry_cnt == 0) begin
      // empty table behaves as a failed search
      cur_pos  = -1;
      r.keep   = 1'b1;
      r.status = est_pkg::ST_LOST;
    end else begin
      nxt = (cur_pos < 0 || cur_pos + 1 >= entry_cnt) ? 0 : cur_pos + 1;
      if (within_tol(elev, sched_elev[nxt])) begin
        cur_pos  = nxt;
        r.keep   = sched_keep[nxt];
        r.status = est_pkg::ST_IN_SEQUENCE;
      end else begin
        // resync: first matching entry from the top of the table
        hit = -1;
        for (i = 0; i < entry_cnt && hit < 0; i++) begin
          if (within_tol(elev, sched_elev[i])) hit = i;
        end
        cur_pos  = hit;
        r.keep   = 1'b1;
        r.status = (hit < 0) ? est_pkg::ST_LOST : est_pkg::ST_RESYNCED;
      end
    end
    r.state_index = cur_pos[est_pkg::SIDX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  int cycle_cnt;
  int fail_cnt;
  int status_tally [5];
  int tol_writes;
  int tx_idle_pct;
  int rx_idle_pct;
  int holdoff_req;    // bumped by the stimulus side to ask for a long stall
  int holdoff_seen;
  int holdoff_left;

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    fail_cnt++;
  endtask

  // run limit, sized well above the slowest legal run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
               classified_due.size());
      $display("tb_elevation_sequence_tracker failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: check each transfer, then pick ready for the next edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    est_pkg::est_result_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (classified_due.size() == 0) begin
          report_mismatch($sformatf("unrequested result keep %0d status %0d index %0d",
                                    result_ch.keep, result_ch.status,
                                    result_ch.state_index));
        end else begin
          want = classified_due.pop_front();
          if (want.status <= est_pkg::ST_FULL) status_tally[want.status]++;
          if (result_ch.keep !== want.keep)
            report_mismatch($sformatf("keep %0d, want %0d", result_ch.keep, want.keep));
          if (result_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", result_ch.status,
                                      want.status));
          if (result_ch.state_index !== want.state_index)
            report_mismatch($sformatf("state_index %0d, want %0d",
                                      result_ch.state_index, want.state_index));
        end
      end
      // long hold-off is counted here, independent of the sender
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_LEN;
      end else if (holdoff_left > 0) begin
        holdoff_left--;
      end
      result_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------
  // called at a rising edge; valid is only lowered when a gap is taken, so
  // back-to-back items keep it high without a second assignment in one step
  task automatic offer_item(logic kind, logic signed [est_pkg::ELEV_W-1:0] elev,
                            logic kflag, logic typed, est_pkg::est_result_t want);
    int                   gap;
    est_pkg::est_result_t predicted;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.kind      <= kind;
    item_ch.elevation <= elev;
    item_ch.keep_flag <= kflag;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    // transfer taken at this edge
    predicted = track_schedule(kind, elev, kflag);
    classified_due.push_back(typed ? want : predicted);
  endtask

  // stop offering and let every owed result come back
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (classified_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_tolerance(int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[est_pkg::TOL_W-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tol_model = value;
    tol_writes++;
  endtask

  function automatic int jitter();
    if (tol_model == 0) return 0;
    return int'($urandom_range(2 * (tol_model - 1))) - (tol_model - 1);
  endfunction

  // mostly sweeps that follow the schedule, plus jumps, tolerance-edge
  // misses, noise and stores (table-full stores once the table is full)
  task automatic run_random_phase(int n_items, bit with_holdoff, bit with_pause);
    int   k;
    int   nxt;
    int   pick;
    int   e;
    logic kind;
    for (k = 0; k < n_items; k++) begin
      if (with_holdoff && k == 40) holdoff_req++;
      if (with_pause && k == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      if ((entry_cnt < TABLE_DEPTH) ? (pick < 25) : (pick < 6)) begin
        kind = est_pkg::KIND_STORE;
        if ($urandom_range(9) == 0) e = int'($urandom_range(32767)) - 16384;
        else                        e = int'($urandom_range(18000)) - 9000;
      end else begin
        kind = est_pkg::KIND_SWEEP;
        nxt  = (cur_pos < 0 || cur_pos + 1 >= entry_cnt) ? 0 : cur_pos + 1;
        pick = $urandom_range(99);
        if (entry_cnt == 0 || pick >= 90) begin
          e = int'($urandom_range(32767)) - 16384;                  // noise
        end else if (pick >= 80) begin
          e = sched_elev[$urandom_range(entry_cnt - 1)] + jitter(); // jump elsewhere
        end else if (pick >= 72) begin
          // exactly at the tolerance: just outside a match
          e = sched_elev[nxt] + ($urandom_range(1) ? tol_model : -tol_model);
        end else begin
          e = sched_elev[nxt] + jitter();                            // in step
        end
      end
      offer_item(kind, e[est_pkg::ELEV_W-1:0], 1'($urandom_range(1)), 1'b0, NO_RESULT);
    end
  endtask

  // directed rows, run with the reset tolerance of 20
  dir_row_t directed_rows [0:19] = '{
    // empty table: any sweep is lost, whatever its keep flag
    {est_pkg::KIND_SWEEP, 15'sd0,      1'b0, 1'b1, 1'b1, est_pkg::ST_LOST,        IDX_LOST},
    {est_pkg::KIND_SWEEP, ELEV_MAX,    1'b1, 1'b1, 1'b1, est_pkg::ST_LOST,        IDX_LOST},
    // entries at both ends of the field and near the tolerance edge
    {est_pkg::KIND_STORE, ELEV_MIN,    1'b0, 1'b1, 1'b0, est_pkg::ST_STORED,      IDX_LOST},
    {est_pkg::KIND_STORE, ELEV_MAX,    1'b1, 1'b1, 1'b0, est_pkg::ST_STORED,      IDX_LOST},
    {est_pkg::KIND_STORE, 15'sd0,      1'b1, 1'b1, 1'b0, est_pkg::ST_STORED,      IDX_LOST},
    {est_pkg::KIND_STORE, 15'sd19,     1'b0, 1'b1, 1'b0, est_pkg::ST_STORED,      IDX_LOST},
    // from lost, the first sweep is tried against entry 0
    {est_pkg::KIND_SWEEP, ELEV_MIN,    1'b0, 1'b1, 1'b0, est_pkg::ST_IN_SEQUENCE, 8'sd0},
    {est_pkg::KIND_SWEEP, ELEV_MAX,    1'b0, 1'b1, 1'b1, est_pkg::ST_IN_SEQUENCE, 8'sd1},
    // difference equal to the tolerance is a miss, search resyncs
    {est_pkg::KIND_SWEEP, 15'sd20,     1'b0, 1'b0, NO_RESULT},
    // wrap past the last entry, then resync on the first hit
    {est_pkg::KIND_SWEEP, -15'sd19,    1'b0, 1'b0, NO_RESULT},
    {est_pkg::KIND_SWEEP, 15'sd38,     1'b0, 1'b0, NO_RESULT},
    {est_pkg::KIND_SWEEP, -15'sd16365, 1'b1, 1'b0, NO_RESULT},
    // nothing near: lost
    {est_pkg::KIND_SWEEP, 15'sd5000,   1'b0, 1'b1, 1'b1, est_pkg::ST_LOST,        IDX_LOST},
    {est_pkg::KIND_SWEEP, 15'sd16364,  1'b0, 1'b0, NO_RESULT},
    {est_pkg::KIND_SWEEP, 15'sd16363,  1'b0, 1'b0, NO_RESULT},
    // two entries match 10, the expected next entry wins over the lower one
    {est_pkg::KIND_SWEEP, -15'sd1,     1'b0, 1'b0, NO_RESULT},
    {est_pkg::KIND_SWEEP, 15'sd10,     1'b1, 1'b0, NO_RESULT},
    {est_pkg::KIND_SWEEP, 15'sd21,     1'b0, 1'b0, NO_RESULT},
    // store while tracking leaves the position alone
    {est_pkg::KIND_STORE, 15'sd8191,   1'b1, 1'b0, NO_RESULT},
    {est_pkg::KIND_SWEEP, 15'sd8200,   1'b0, 1'b0, NO_RESULT}
  };

  // per phase: tolerance (negative = random in range) and item count
  int phase_tol   [NUM_PHASES] = '{1000, 0, 1023, 1, 20, -1};
  int phase_items [NUM_PHASES] = '{260, 80, 200, 240, 260, 250};

  initial begin
    int ph;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    item_ch.valid     = 1'b0;
    item_ch.kind      = est_pkg::KIND_STORE;
    item_ch.elevation = '0;
    item_ch.keep_flag = 1'b0;
    entry_cnt    = 0;
    cur_pos      = -1;
    tol_model    = int'(est_pkg::TOL_RESET);
    holdoff_req  = 0;
    holdoff_seen = 0;
    holdoff_left = 0;
    tx_idle_pct  = 21;
    rx_idle_pct  = 55;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].kind, directed_rows[i].elev, directed_rows[i].keep_flag,
                 directed_rows[i].typed, directed_rows[i].want);
    end
    wait_drained();

    // idling: sender light / receiver heavy, then swapped, then none
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 55 : 0;
      rx_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 21 : 0;
      write_tolerance((phase_tol[ph] < 0) ? int'($urandom_range(999, 2)) : phase_tol[ph]);
      run_random_phase(phase_items[ph], ph == 0, ph == 3);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d results: %0d in step, %0d resynced, %0d lost, %0d stored, %0d full",
             status_tally[0] + status_tally[1] + status_tally[2] + status_tally[3] +
             status_tally[4], status_tally[est_pkg::ST_IN_SEQUENCE],
             status_tally[est_pkg::ST_RESYNCED], status_tally[est_pkg::ST_LOST],
             status_tally[est_pkg::ST_STORED], status_tally[est_pkg::ST_FULL]);
    $display("%0d tolerance settings incl. 0 and 1023, %0d table entries, %0d mismatches",
             tol_writes, entry_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_elevation_sequence_tracker passed");
    end else begin
      $display("tb_elevation_sequence_tracker failed");
    end
    $finish;
  end

endmodule
